// ===== hdl/rsg_pkg.sv =====
package rsg_pkg;

  localparam int NUM_AXES     = 3;
  localparam int REGION_DEPTH = 256;
  localparam int FRAME_DEPTH  = 16384;
  localparam int LOCAL_DEPTH  = 4096;

  localparam int REGION_AW = $clog2(REGION_DEPTH);
  localparam int FRAME_AW  = $clog2(FRAME_DEPTH);
  localparam int OFF_W     = 14;
  localparam int ROW_W     = OFF_W * NUM_AXES;
  localparam int ENTRY_W   = 48;
  localparam int LEXT_W    = 11;
  localparam int GEXT_W    = 15;
  localparam int LIDX_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  typedef enum logic [2:0] {
    CMD_LOAD_SOURCE = 3'd0,
    CMD_LOAD_FRAME  = 3'd1,
    CMD_SET_OFFSET  = 3'd2,
    CMD_WEIGHT      = 3'd3,
    CMD_READ_SOURCE = 3'd4,
    CMD_READ_FRAME  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_LOCAL_A   = 3'd0,
    REG_LOCAL_B   = 3'd1,
    REG_LOCAL_C   = 3'd2,
    REG_GLOBAL_A  = 3'd3,
    REG_GLOBAL_B  = 3'd4,
    REG_MODE      = 3'd5,
    REG_REGIONS   = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ADDR0,
    S_ADDR1,
    S_ADDR2,
    S_ADDR3,
    S_MEMRD,
    S_MAC_LO,
    S_MAC_HI,
    S_SUM,
    S_OFFWR,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         region_index;
    logic [13:0]        frame_address;
    logic [1:0]         axis;
    logic [11:0]        local_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] weight;
    logic [13:0]        placement;
  } item_t;

  typedef struct packed {
    logic signed [47:0] read_value;
    logic [1:0]         status;
  } result_t;

endpackage

// ===== hdl/rsg_ram.sv =====
module rsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/roi_scatter_gather_mac.sv =====
// Weights take 36 steps of one shared restoring divider, then 4 address and 4
// multiply-accumulate steps on one shared multiplier; skipped weights and loads go
// straight to the result, reads and offset writes through one wait or write state. One
// transaction at a time: items are taken only when idle, after the result register loads,
// and a result not yet taken holds the block. Synchronous active-high reset clears control
// state, mode, region count, offset row valid bits (offsets read 0); extents reset to 1.
module roi_scatter_gather_mac
  import rsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  state_t state, state_next;

  logic [LEXT_W-1:0] local_a, local_b, local_c;
  logic [GEXT_W-1:0] global_a, global_b;
  logic              mode;
  logic [8:0]        region_count;

  item_t item_q;
  logic  accept;

  logic [LEXT_W-1:0] div_rem;
  logic [LIDX_W-1:0] div_quo;
  logic [3:0]        div_step;
  logic [1:0]        div_k;
  logic [LEXT_W-1:0] sub [NUM_AXES];

  logic [OFF_W-1:0]  off [NUM_AXES];
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [46:0]       faddr_full;
  logic [FRAME_AW-1:0] faddr;
  logic signed [32:0] q_lo;
  logic signed [47:0] acc_v;
  logic [31:0]       v_hi;

  logic [1:0]        res_status;
  logic signed [47:0] res_value;

  logic [REGION_DEPTH-1:0] off_valid;

  // memory ports
  logic                src_we, frm_we, off_we;
  logic [REGION_AW-1:0] src_waddr, src_raddr, off_raddr;
  logic [FRAME_AW-1:0]  frm_waddr, frm_raddr;
  logic [ENTRY_W-1:0]   src_wdata, frm_wdata, src_rdata, frm_rdata;
  logic [ROW_W-1:0]     off_wdata, off_rdata, off_row;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_a      <= LEXT_W'(1);
      local_b      <= LEXT_W'(1);
      local_c      <= LEXT_W'(1);
      global_a     <= GEXT_W'(1);
      global_b     <= GEXT_W'(1);
      mode         <= 1'b0;
      region_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_A:  local_a      <= cfg_data[LEXT_W-1:0];
        REG_LOCAL_B:  local_b      <= cfg_data[LEXT_W-1:0];
        REG_LOCAL_C:  local_c      <= cfg_data[LEXT_W-1:0];
        REG_GLOBAL_A: global_a     <= cfg_data;
        REG_GLOBAL_B: global_b     <= cfg_data;
        REG_MODE:     mode         <= cfg_data[0];
        REG_REGIONS:  region_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // divisor for the current axis
  logic [LEXT_W-1:0] div_e;
  always_comb begin
    case (div_k)
      2'd0:    div_e = local_a;
      2'd1:    div_e = local_b;
      default: div_e = local_c;
    endcase
  end

  logic [LEXT_W:0]   trial;
  logic              trial_ge;
  logic [LEXT_W-1:0] rem_new;
  assign trial    = {div_rem, div_quo[LIDX_W-1]};
  assign trial_ge = (trial >= {1'b0, div_e});
  assign rem_new  = trial_ge ? LEXT_W'(trial - {1'b0, div_e}) : trial[LEXT_W-1:0];

  // offsets of the item's region, zero for a row never written
  assign off_row = off_valid[item_q.region_index] ? off_rdata : '0;
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_off
    assign off[g] = off_row[g*OFF_W +: OFF_W];
    assign off_wdata[g*OFF_W +: OFF_W] =
        (item_q.axis == 2'(g)) ? item_q.placement : off_row[g*OFF_W +: OFF_W];
  end

  logic [GEXT_W-1:0] term [NUM_AXES];
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_term
    assign term[g] = GEXT_W'(sub[g]) + GEXT_W'(off[g]);
  end

  logic [30:0] addr_mid;
  assign addr_mid   = mul_p[30:0] + 31'(term[1]);
  assign faddr_full = 47'(mul_p[45:0]) + 47'(term[0]);

  // operands of the multiply-accumulate
  logic [ENTRY_W-1:0] mac_v, mac_acc;
  assign mac_v   = mode ? frm_rdata : src_rdata;
  assign mac_acc = mode ? src_rdata : frm_rdata;

  logic signed [65:0] mac_sum;
  logic signed [47:0] mac_sat;
  logic               mac_ovf;
  assign mac_sum = 66'(acc_v) + mul_p + 66'(q_lo);
  always_comb begin
    mac_ovf = 1'b1;
    if (mac_sum > 66'sh7FFFFFFFFFFF) begin
      mac_sat = 48'sh7FFFFFFFFFFF;
    end else if (mac_sum < -66'sh800000000000) begin
      mac_sat = -48'sh800000000000;
    end else begin
      mac_sat = mac_sum[47:0];
      mac_ovf = 1'b0;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ADDR1: begin
        mul_a = 33'(term[2]);
        mul_b = 33'(global_b);
      end
      S_ADDR2: begin
        mul_a = 33'(addr_mid);
        mul_b = 33'(global_a);
      end
      S_MAC_LO: begin
        mul_a = 33'(item_q.weight);
        mul_b = $signed({17'd0, mac_v[15:0]});
      end
      S_MAC_HI: begin
        mul_a = 33'(item_q.weight);
        mul_b = 33'($signed(v_hi));
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.cmd)
            CMD_LOAD_SOURCE, CMD_LOAD_FRAME: state_next = S_DONE;
            CMD_SET_OFFSET:  state_next = (32'(item.axis) < NUM_AXES) ? S_OFFWR : S_DONE;
            CMD_READ_SOURCE, CMD_READ_FRAME: state_next = S_RDWAIT;
            CMD_WEIGHT: begin
              if (item.weight == 0 || 9'(item.region_index) >= region_count ||
                  local_a == 0 || local_b == 0 || local_c == 0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_DIV;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (div_step == 4'(LIDX_W - 1) && div_k == 2'(NUM_AXES - 1)) begin
          state_next = S_ADDR0;
        end
      end
      S_ADDR0:  state_next = (div_quo != 0) ? S_DONE : S_ADDR1;
      S_ADDR1:  state_next = S_ADDR2;
      S_ADDR2:  state_next = S_ADDR3;
      S_ADDR3:  state_next = (faddr_full >= 47'(FRAME_DEPTH)) ? S_DONE : S_MEMRD;
      S_MEMRD:  state_next = S_MAC_LO;
      S_MAC_LO: state_next = S_MAC_HI;
      S_MAC_HI: state_next = S_SUM;
      S_SUM:    state_next = S_DONE;
      S_OFFWR:  state_next = S_DONE;
      S_RDWAIT: state_next = S_DONE;
      S_DONE:   state_next = (!result_valid || result_ready) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (accept) begin
          item_q    <= item;
          div_quo   <= item.local_index;
          div_rem   <= '0;
          div_step  <= '0;
          div_k     <= '0;
          res_value <= '0;
          res_status <= ST_OK;
          if ((item.cmd == CMD_SET_OFFSET && !(32'(item.axis) < NUM_AXES)) ||
              item.cmd > CMD_READ_FRAME ||
              (item.cmd == CMD_WEIGHT && item.weight != 0 &&
               (9'(item.region_index) >= region_count ||
                local_a == 0 || local_b == 0 || local_c == 0))) begin
            res_status <= ST_RANGE;
          end
        end
      end
      S_DIV: begin
        div_quo <= {div_quo[LIDX_W-2:0], trial_ge};
        if (div_step == 4'(LIDX_W - 1)) begin
          sub[div_k] <= rem_new;
          div_rem    <= '0;
          div_step   <= '0;
          div_k      <= div_k + 2'd1;
        end else begin
          div_rem  <= rem_new;
          div_step <= div_step + 4'd1;
        end
      end
      S_ADDR0: begin
        if (div_quo != 0) res_status <= ST_RANGE;
      end
      S_ADDR3: begin
        faddr <= faddr_full[FRAME_AW-1:0];
        if (faddr_full >= 47'(FRAME_DEPTH)) res_status <= ST_RANGE;
      end
      S_MAC_LO: begin
        acc_v <= mac_acc;
        v_hi  <= mac_v[47:16];
      end
      S_MAC_HI: begin
        q_lo <= 33'(($signed(mul_p[48:0]) + 49'sd32768) >>> 16);
      end
      S_SUM: begin
        if (mac_ovf) res_status <= ST_SAT;
      end
      S_RDWAIT: begin
        res_value <= (item_q.cmd == CMD_READ_SOURCE) ? src_rdata : frm_rdata;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || result_ready)) begin
      result.read_value <= res_value;
      result.status     <= res_status;
    end
  end

  // offset row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      off_valid <= '0;
    end else if (off_we) begin
      off_valid[item_q.region_index] <= 1'b1;
    end
  end

  // memory port control
  assign src_raddr = accept ? item.region_index : item_q.region_index;
  assign off_raddr = src_raddr;
  assign frm_raddr = accept ? item.frame_address
                   : ((state == S_MEMRD) ? faddr : item_q.frame_address);

  always_comb begin
    src_we    = 1'b0;
    src_waddr = item.region_index;
    src_wdata = ENTRY_W'(item.sample_value);
    frm_we    = 1'b0;
    frm_waddr = item.frame_address;
    frm_wdata = ENTRY_W'(item.sample_value);
    if (accept && item.cmd == CMD_LOAD_SOURCE) src_we = 1'b1;
    if (accept && item.cmd == CMD_LOAD_FRAME)  frm_we = 1'b1;
    if (state == S_SUM) begin
      if (mode) begin
        src_we    = 1'b1;
        src_waddr = item_q.region_index;
        src_wdata = mac_sat;
      end else begin
        frm_we    = 1'b1;
        frm_waddr = faddr;
        frm_wdata = mac_sat;
      end
    end
  end

  assign off_we = (state == S_OFFWR);

  rsg_ram #(.WIDTH(ENTRY_W), .DEPTH(REGION_DEPTH)) u_source (
    .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
    .raddr(src_raddr), .rdata(src_rdata)
  );

  rsg_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk(clk), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
    .raddr(frm_raddr), .rdata(frm_rdata)
  );

  rsg_ram #(.WIDTH(ROW_W), .DEPTH(REGION_DEPTH)) u_offset (
    .clk(clk), .we(off_we), .waddr(item_q.region_index), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  // checks
  a_div_axis: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_k < 2'(NUM_AXES))
    else $error("divider axis counter out of range");

  a_sat_no_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_SAT |-> result.read_value == 0)
    else $error("saturated accumulate returned a read value");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !result_valid |=> result_valid)
    else $error("finished transaction did not reach result register");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("accepted a second transaction while busy");

endmodule
